### src/fcbb_pkg.sv
// Shared types and constants for the frame change bounding box block.
`timescale 1ns / 1ps

package fcbb_pkg;

  localparam int unsigned COL_W  = 10;
  localparam int unsigned ROW_W  = 10;
  localparam int unsigned PIX_W  = 32;
  localparam int unsigned DIM_W  = 11;
  localparam int unsigned BOX_W  = 10;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  localparam logic [DIM_W-1:0] FRAME_WIDTH_RST  = 11'd1024;
  localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = 11'd768;

  // Entries in the queue between classification and the store side.
  localparam int unsigned QUEUE_DEPTH = 4;

  typedef enum logic {
    CMD_REF = 1'b0,
    CMD_CMP = 1'b1
  } cmd_e;

  // A word after classification: the raw fields plus whether it hits the store.
  typedef struct packed {
    cmd_e              cmd;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic [PIX_W-1:0]  pixel;
    logic              last;
    logic              hit;
  } class_t;

endpackage

### src/fcbb_if.sv
// Stream interfaces for the pixel input and the box result channels.
`timescale 1ns / 1ps

interface fcbb_in_if;
  logic                            valid;
  logic                            ready;
  logic                            command;
  logic [fcbb_pkg::COL_W-1:0]      col;
  logic [fcbb_pkg::ROW_W-1:0]      row;
  logic [fcbb_pkg::PIX_W-1:0]      pixel;
  logic                            frame_last;

  modport source (output valid, command, col, row, pixel, frame_last, input ready);
  modport sink   (input valid, command, col, row, pixel, frame_last, output ready);
endinterface

interface fcbb_out_if;
  logic                            valid;
  logic                            ready;
  logic                            changed;
  logic [fcbb_pkg::BOX_W-1:0]      left;
  logic [fcbb_pkg::BOX_W-1:0]      top;
  logic [fcbb_pkg::BOX_W-1:0]      right;
  logic [fcbb_pkg::BOX_W-1:0]      bottom;

  modport source (output valid, changed, left, top, right, bottom, input ready);
  modport sink   (input valid, changed, left, top, right, bottom, output ready);
endinterface

### src/fcbb_front.sv
// Front end: accepts pixel words, checks frame bounds and sampling, forms the store index.
`timescale 1ns / 1ps

module fcbb_front #(
  parameter int unsigned MAX_WIDTH   = 1024,
  parameter int unsigned MAX_HEIGHT  = 1024,
  parameter int unsigned SAMPLE_STEP = 4,
  parameter int unsigned IDX_W       = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  fcbb_in_if.sink                      pix_i,
  input  logic [fcbb_pkg::DIM_W-1:0]   frame_width_i,
  input  logic [fcbb_pkg::DIM_W-1:0]   frame_height_i,
  output logic                         cls_valid_o,
  input  logic                         cls_ready_i,
  output fcbb_pkg::class_t             cls_item_o,
  output logic [IDX_W-1:0]             cls_idx_o
);

  localparam int unsigned GRID_COLS = (MAX_WIDTH + SAMPLE_STEP - 1) / SAMPLE_STEP;
  localparam int unsigned QUO_SHIFT = 16;
  localparam int unsigned RECIP     = ((1 << QUO_SHIFT) + SAMPLE_STEP - 1) / SAMPLE_STEP;
  localparam int unsigned PROD_W    = 27;
  localparam int unsigned LIM_W     = 14;
  localparam int unsigned SUM_W     = 25;

  // Stage one: bounds check and quotients by the sample step.
  logic                              s1_valid_q;
  fcbb_pkg::class_t                  s1_item_q;
  logic [fcbb_pkg::COL_W-1:0]        s1_cq_q;
  logic [fcbb_pkg::ROW_W-1:0]        s1_rq_q;
  // Stage two: classified word with store index.
  logic                              s2_valid_q;
  fcbb_pkg::class_t                  s2_item_q, s2_item_d;
  logic [IDX_W-1:0]                  s2_idx_q;

  logic                              s1_ready;
  logic                              s2_ready;
  logic                              in_frame;
  logic [PROD_W-1:0]                 col_prod;
  logic [PROD_W-1:0]                 row_prod;
  logic [LIM_W-1:0]                  col_back;
  logic [LIM_W-1:0]                  row_back;
  logic                              sampled;
  logic [SUM_W-1:0]                  idx_full;

  assign s2_ready    = !s2_valid_q || cls_ready_i;
  assign s1_ready    = !s1_valid_q || s2_ready;
  assign pix_i.ready = s1_ready;

  // Multiplying by a rounded-up reciprocal gives the exact quotient for 10-bit values.
  assign col_prod = PROD_W'(pix_i.col) * PROD_W'(RECIP);
  assign row_prod = PROD_W'(pix_i.row) * PROD_W'(RECIP);

  assign in_frame = ({1'b0, pix_i.col} < frame_width_i) &&
                    ({1'b0, pix_i.row} < frame_height_i) &&
                    (LIM_W'(pix_i.col) < LIM_W'(MAX_WIDTH)) &&
                    (LIM_W'(pix_i.row) < LIM_W'(MAX_HEIGHT));

  assign col_back = LIM_W'(s1_cq_q) * LIM_W'(SAMPLE_STEP);
  assign row_back = LIM_W'(s1_rq_q) * LIM_W'(SAMPLE_STEP);
  assign sampled  = (col_back == LIM_W'(s1_item_q.col)) && (row_back == LIM_W'(s1_item_q.row));
  assign idx_full = SUM_W'(s1_rq_q) * SUM_W'(GRID_COLS) + SUM_W'(s1_cq_q);

  // The stored word only counts when it is both in the frame and on the sample grid.
  always_comb begin
    s2_item_d     = s1_item_q;
    s2_item_d.hit = s1_item_q.hit && sampled;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= pix_i.valid;
      end
      if (s2_ready) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_i.valid && s1_ready) begin
      s1_item_q <= '{cmd:   fcbb_pkg::cmd_e'(pix_i.command),
                     col:   pix_i.col,
                     row:   pix_i.row,
                     pixel: pix_i.pixel,
                     last:  pix_i.frame_last,
                     hit:   in_frame};
      s1_cq_q   <= col_prod[QUO_SHIFT+fcbb_pkg::COL_W-1:QUO_SHIFT];
      s1_rq_q   <= row_prod[QUO_SHIFT+fcbb_pkg::ROW_W-1:QUO_SHIFT];
    end
    if (s1_valid_q && s2_ready) begin
      s2_item_q <= s2_item_d;
      s2_idx_q  <= idx_full[IDX_W-1:0];
    end
  end

  assign cls_valid_o = s2_valid_q;
  assign cls_item_o  = s2_item_q;
  assign cls_idx_o   = s2_idx_q;

endmodule

### src/fcbb_queue.sv
// Short queue that decouples classification from the store side.
`timescale 1ns / 1ps

module fcbb_queue #(
  parameter int unsigned IDX_W = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_valid_i,
  output logic                 push_ready_o,
  input  fcbb_pkg::class_t     push_item_i,
  input  logic [IDX_W-1:0]     push_idx_i,
  output logic                 pop_valid_o,
  input  logic                 pop_ready_i,
  output fcbb_pkg::class_t     pop_item_o,
  output logic [IDX_W-1:0]     pop_idx_o
);

  localparam int unsigned DEPTH = fcbb_pkg::QUEUE_DEPTH;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  fcbb_pkg::class_t        item_q [DEPTH];
  logic [IDX_W-1:0]        idx_q  [DEPTH];
  logic [PTR_W-1:0]        wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]        rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]        count_q, count_d;
  logic                    do_push;
  logic                    do_pop;

  assign push_ready_o = (count_q != CNT_W'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;
  assign pop_item_o   = item_q[rd_ptr_q];
  assign pop_idx_o    = idx_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      item_q[wr_ptr_q] <= push_item_i;
      idx_q[wr_ptr_q]  <= push_idx_i;
    end
  end

endmodule

### src/fcbb_back.sv
// Back end: reference store access, difference test, running box and result register.
`timescale 1ns / 1ps

module fcbb_back #(
  parameter int unsigned SAMPLE_STEP = 4,
  parameter int unsigned STORE_DEPTH = 65536,
  parameter int unsigned IDX_W       = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cls_valid_i,
  output logic                         cls_ready_o,
  input  fcbb_pkg::class_t             cls_item_i,
  input  logic [IDX_W-1:0]             cls_idx_i,
  input  logic [fcbb_pkg::DIM_W-1:0]   frame_width_i,
  input  logic [fcbb_pkg::DIM_W-1:0]   frame_height_i,
  fcbb_out_if.source                   box_o
);

  localparam int unsigned BOX_W = fcbb_pkg::BOX_W;
  localparam int unsigned DIM_W = fcbb_pkg::DIM_W;
  localparam int unsigned PIX_W = fcbb_pkg::PIX_W;
  localparam logic [BOX_W-1:0] WIDEN = BOX_W'(SAMPLE_STEP - 1);

  logic [PIX_W-1:0]        ref_mem [STORE_DEPTH];

  logic                    r_valid_q;
  fcbb_pkg::class_t        r_item_q;
  logic [IDX_W-1:0]        r_idx_q;
  logic [PIX_W-1:0]        rdata_q;
  logic                    byp_hit_q;
  logic [PIX_W-1:0]        byp_data_q;

  logic                    found_q, found_d;
  logic [BOX_W-1:0]        min_col_q, min_col_d;
  logic [BOX_W-1:0]        min_row_q, min_row_d;
  logic [BOX_W-1:0]        max_col_q, max_col_d;
  logic [BOX_W-1:0]        max_row_q, max_row_d;

  logic                    out_valid_q;
  logic                    changed_q;
  logic [BOX_W-1:0]        left_q, top_q, right_q, bottom_q;

  logic                    res_needed;
  logic                    r_leave;
  logic                    load;
  logic [PIX_W-1:0]        ref_word;
  logic                    differs;
  logic [BOX_W-1:0]        left_n, top_n;
  logic [DIM_W-1:0]        right_sum, bottom_sum;
  logic [DIM_W-1:0]        right_n, bottom_n;

  assign res_needed  = (r_item_q.cmd == fcbb_pkg::CMD_CMP) && r_item_q.last;
  assign r_leave     = r_valid_q && (!res_needed || !out_valid_q || box_o.ready);
  assign load        = cls_valid_i && (!r_valid_q || r_leave);
  assign cls_ready_o = !r_valid_q || r_leave;

  // The word leaving in the same cycle as a read writes the store too late for that read.
  assign ref_word = byp_hit_q ? byp_data_q : rdata_q;
  assign differs  = r_item_q.hit && (r_item_q.cmd == fcbb_pkg::CMD_CMP) &&
                    (ref_word != r_item_q.pixel);

  always_comb begin
    found_d   = found_q || differs;
    min_col_d = (differs && r_item_q.col < min_col_q) ? r_item_q.col : min_col_q;
    min_row_d = (differs && r_item_q.row < min_row_q) ? r_item_q.row : min_row_q;
    max_col_d = (differs && r_item_q.col > max_col_q) ? r_item_q.col : max_col_q;
    max_row_d = (differs && r_item_q.row > max_row_q) ? r_item_q.row : max_row_q;
  end

  // Widen by step minus one and clamp to the frame.
  always_comb begin
    left_n     = (min_col_d > WIDEN) ? min_col_d - WIDEN : '0;
    top_n      = (min_row_d > WIDEN) ? min_row_d - WIDEN : '0;
    right_sum  = {1'b0, max_col_d} + {1'b0, WIDEN};
    bottom_sum = {1'b0, max_row_d} + {1'b0, WIDEN};
    right_n    = right_sum;
    bottom_n   = bottom_sum;
    if ((frame_width_i != '0) && (right_sum > frame_width_i - 1'b1)) begin
      right_n = frame_width_i - 1'b1;
    end
    if ((frame_height_i != '0) && (bottom_sum > frame_height_i - 1'b1)) begin
      bottom_n = frame_height_i - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (r_leave && r_item_q.hit) begin
      ref_mem[r_idx_q] <= r_item_q.pixel;
    end
    if (load) begin
      rdata_q  <= ref_mem[cls_idx_i];
      r_item_q <= cls_item_i;
      r_idx_q  <= cls_idx_i;
      byp_data_q <= r_item_q.pixel;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_valid_q <= 1'b0;
      byp_hit_q <= 1'b0;
    end else begin
      if (cls_ready_o) begin
        r_valid_q <= cls_valid_i;
      end
      if (load) begin
        byp_hit_q <= r_leave && r_item_q.hit && (r_idx_q == cls_idx_i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q   <= 1'b0;
      min_col_q <= '1;
      min_row_q <= '1;
      max_col_q <= '0;
      max_row_q <= '0;
    end else if (r_leave) begin
      if (res_needed) begin
        found_q   <= 1'b0;
        min_col_q <= '1;
        min_row_q <= '1;
        max_col_q <= '0;
        max_row_q <= '0;
      end else begin
        found_q   <= found_d;
        min_col_q <= min_col_d;
        min_row_q <= min_row_d;
        max_col_q <= max_col_d;
        max_row_q <= max_row_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (r_leave && res_needed) begin
      out_valid_q <= 1'b1;
    end else if (box_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (r_leave && res_needed) begin
      changed_q <= found_d;
      left_q    <= found_d ? left_n : '0;
      top_q     <= found_d ? top_n : '0;
      right_q   <= found_d ? right_n[BOX_W-1:0] : '0;
      bottom_q  <= found_d ? bottom_n[BOX_W-1:0] : '0;
    end
  end

  assign box_o.valid   = out_valid_q;
  assign box_o.changed = changed_q;
  assign box_o.left    = left_q;
  assign box_o.top     = top_q;
  assign box_o.right   = right_q;
  assign box_o.bottom  = bottom_q;

endmodule

### src/frame_change_bounding_box_top.sv
// Top level of the frame change bounding box block: config registers and the datapath.
//
// Pixel words enter on pix_i (valid/ready): a command bit (reference or compare),
// column, row, a 32-bit pixel and a frame-last flag. Only pixels on the sample grid
// and inside the frame touch the reference store. Reference words are stored;
// compare words that differ grow a running box and overwrite the stored word.
// The last word of a compare frame produces one result word on box_o (valid/ready):
// a changed flag and the box widened by SAMPLE_STEP-1 and clamped to the frame.
// Throughput is one pixel word per cycle unless box_o stalls: the front end classifies in
// two stages, a four-entry queue feeds the back end, and the back end does one store read
// and one store write per cycle, with a forwarding path for back-to-back hits. A frame-last
// word goes through both front-end stages, the queue and the read register to box_o.
// If the receiver holds box_o.ready low, the result stays in the output register,
// the back end holds at the next frame-last compare word, and the queue and then
// pix_i.ready back up; words that produce no result keep flowing meanwhile.
// Reset empties the pipeline, clears the box and loads frame_width 1024 and
// frame_height 768. The reference store has no reset; compare frames are meaningful
// only after a reference frame has filled the store.
// Config writes (cfg_we_i, cfg_idx_i, cfg_data_i) take effect at the next edge.
`timescale 1ns / 1ps

module frame_change_bounding_box_top #(
  parameter int unsigned MAX_WIDTH   = 1024,
  parameter int unsigned MAX_HEIGHT  = 1024,
  parameter int unsigned SAMPLE_STEP = 4
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [fcbb_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [fcbb_pkg::DIM_W-1:0]         cfg_data_i,
  fcbb_in_if.sink                            pix_i,
  fcbb_out_if.source                         box_o
);

  localparam int unsigned GRID_COLS   = (MAX_WIDTH + SAMPLE_STEP - 1) / SAMPLE_STEP;
  localparam int unsigned GRID_ROWS   = (MAX_HEIGHT + SAMPLE_STEP - 1) / SAMPLE_STEP;
  localparam int unsigned STORE_DEPTH = GRID_COLS * GRID_ROWS;
  localparam int unsigned IDX_W       = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  logic [fcbb_pkg::DIM_W-1:0] frame_width_q;
  logic [fcbb_pkg::DIM_W-1:0] frame_height_q;

  logic                       f_valid, f_ready;
  fcbb_pkg::class_t           f_item;
  logic [IDX_W-1:0]           f_idx;
  logic                       b_valid, b_ready;
  fcbb_pkg::class_t           b_item;
  logic [IDX_W-1:0]           b_idx;

  // Configuration registers; write only while the block is idle (the block does not enforce it).
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= fcbb_pkg::FRAME_WIDTH_RST;
      frame_height_q <= fcbb_pkg::FRAME_HEIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        fcbb_pkg::REG_FRAME_WIDTH: begin
          frame_width_q <= cfg_data_i;
        end
        fcbb_pkg::REG_FRAME_HEIGHT: begin
          frame_height_q <= cfg_data_i;
        end
        default: begin
        end
      endcase
    end
  end

  fcbb_front #(
    .MAX_WIDTH   (MAX_WIDTH),
    .MAX_HEIGHT  (MAX_HEIGHT),
    .SAMPLE_STEP (SAMPLE_STEP),
    .IDX_W       (IDX_W)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .pix_i          (pix_i),
    .frame_width_i  (frame_width_q),
    .frame_height_i (frame_height_q),
    .cls_valid_o    (f_valid),
    .cls_ready_i    (f_ready),
    .cls_item_o     (f_item),
    .cls_idx_o      (f_idx)
  );

  fcbb_queue #(
    .IDX_W (IDX_W)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_item_i  (f_item),
    .push_idx_i   (f_idx),
    .pop_valid_o  (b_valid),
    .pop_ready_i  (b_ready),
    .pop_item_o   (b_item),
    .pop_idx_o    (b_idx)
  );

  fcbb_back #(
    .SAMPLE_STEP (SAMPLE_STEP),
    .STORE_DEPTH (STORE_DEPTH),
    .IDX_W       (IDX_W)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cls_valid_i    (b_valid),
    .cls_ready_o    (b_ready),
    .cls_item_i     (b_item),
    .cls_idx_i      (b_idx),
    .frame_width_i  (frame_width_q),
    .frame_height_i (frame_height_q),
    .box_o          (box_o)
  );

endmodule
